// ----- rtl/ist_pkg.sv -----
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types, codes and character classes for the INI stream tokenizer.
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam logic [3:0] M_BETWEEN   = 4'd0;
  localparam logic [3:0] M_COMMENT   = 4'd1;
  localparam logic [3:0] M_SEC_START = 4'd2;
  localparam logic [3:0] M_SEC_NAME  = 4'd3;
  localparam logic [3:0] M_DROP      = 4'd4;
  localparam logic [3:0] M_KEY       = 4'd5;
  localparam logic [3:0] M_BEFORE_EQ = 4'd6;
  localparam logic [3:0] M_AFTER_EQ  = 4'd7;
  localparam logic [3:0] M_VALUE     = 4'd8;
  localparam logic [3:0] M_ERROR     = 4'd9;

  localparam logic [2:0] K_SEC_CHAR = 3'd0;
  localparam logic [2:0] K_SEC_END  = 3'd1;
  localparam logic [2:0] K_KEY_CHAR = 3'd2;
  localparam logic [2:0] K_VAL_CHAR = 3'd3;
  localparam logic [2:0] K_PAIR_END = 3'd4;
  localparam logic [2:0] K_DONE     = 3'd5;
  localparam logic [2:0] K_ERROR    = 3'd6;

  localparam logic [2:0] E_ILLEGAL     = 3'd0;
  localparam logic [2:0] E_BAD_SECTION = 3'd1;
  localparam logic [2:0] E_NO_BRACKET  = 3'd2;
  localparam logic [2:0] E_NO_EQUALS   = 3'd3;
  localparam logic [2:0] E_EARLY_END   = 3'd4;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_out;
    logic [2:0] err_code;
    logic       last;
  } res_t;

  function automatic logic is_name(input logic [7:0] c);
    is_name = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
              (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

endpackage

// ----- rtl/ist_decode.sv -----
// ----------------------------------------------------------------------------
// ist_decode
// Next mode and up to two result items from the current mode and one input.
// ----------------------------------------------------------------------------
module ist_decode (
  input  logic [3:0]    mode,
  input  logic          op,
  input  logic [7:0]    data_byte,
  output logic [3:0]    mode_nxt,
  output logic [1:0]    res_cnt,
  output ist_pkg::res_t res0,
  output ist_pkg::res_t res1
);
  import ist_pkg::*;

  logic nm;
  logic sp;

  assign nm = is_name(data_byte);
  assign sp = is_space(data_byte);

  always_comb begin
    mode_nxt = mode;
    res_cnt  = 2'd0;
    res0     = '{kind: K_SEC_CHAR, char_out: 8'd0, err_code: 3'd0, last: 1'b1};
    res1     = '{kind: K_DONE, char_out: 8'd0, err_code: 3'd0, last: 1'b1};
    if (op == OP_END) begin
      unique case (mode)
        M_BETWEEN, M_DROP: begin
          mode_nxt   = M_BETWEEN;
          res_cnt    = 2'd1;
          res0.kind  = K_DONE;
        end
        M_AFTER_EQ, M_VALUE: begin
          mode_nxt   = M_BETWEEN;
          res_cnt    = 2'd2;
          res0.kind  = K_PAIR_END;
          res0.last  = 1'b0;
        end
        M_COMMENT, M_SEC_START, M_SEC_NAME, M_KEY, M_BEFORE_EQ: begin
          mode_nxt      = M_ERROR;
          res_cnt       = 2'd1;
          res0.kind     = K_ERROR;
          res0.err_code = E_EARLY_END;
        end
        default: mode_nxt = M_ERROR;
      endcase
    end else begin
      unique case (mode)
        M_BETWEEN: begin
          if (sp) begin
            mode_nxt = M_BETWEEN;
          end else if (data_byte == CH_LBRACK) begin
            mode_nxt = M_SEC_START;
          end else if (data_byte == CH_SEMI) begin
            mode_nxt = M_COMMENT;
          end else if (nm) begin
            mode_nxt      = M_KEY;
            res_cnt       = 2'd1;
            res0.kind     = K_KEY_CHAR;
            res0.char_out = data_byte;
          end else begin
            mode_nxt      = M_ERROR;
            res_cnt       = 2'd1;
            res0.kind     = K_ERROR;
            res0.err_code = E_ILLEGAL;
          end
        end
        M_COMMENT: begin
          if (data_byte == CH_LF) mode_nxt = M_BETWEEN;
        end
        M_SEC_START: begin
          res_cnt = 2'd1;
          if (nm) begin
            mode_nxt      = M_SEC_NAME;
            res0.kind     = K_SEC_CHAR;
            res0.char_out = data_byte;
          end else begin
            mode_nxt      = M_ERROR;
            res0.kind     = K_ERROR;
            res0.err_code = E_BAD_SECTION;
          end
        end
        M_SEC_NAME: begin
          res_cnt = 2'd1;
          if (nm) begin
            res0.kind     = K_SEC_CHAR;
            res0.char_out = data_byte;
          end else if (data_byte == CH_RBRACK) begin
            mode_nxt  = M_DROP;
            res0.kind = K_SEC_END;
          end else begin
            mode_nxt      = M_ERROR;
            res0.kind     = K_ERROR;
            res0.err_code = E_NO_BRACKET;
          end
        end
        M_DROP: mode_nxt = M_BETWEEN;
        M_KEY: begin
          if (nm) begin
            res_cnt       = 2'd1;
            res0.kind     = K_KEY_CHAR;
            res0.char_out = data_byte;
          end else if (data_byte == CH_EQ) begin
            mode_nxt = M_AFTER_EQ;
          end else if (sp) begin
            mode_nxt = M_BEFORE_EQ;
          end else begin
            mode_nxt      = M_ERROR;
            res_cnt       = 2'd1;
            res0.kind     = K_ERROR;
            res0.err_code = E_NO_EQUALS;
          end
        end
        M_BEFORE_EQ: begin
          if (data_byte == CH_EQ) begin
            mode_nxt = M_AFTER_EQ;
          end else if (!sp) begin
            mode_nxt      = M_ERROR;
            res_cnt       = 2'd1;
            res0.kind     = K_ERROR;
            res0.err_code = E_NO_EQUALS;
          end
        end
        M_AFTER_EQ: begin
          if (nm) begin
            mode_nxt      = M_VALUE;
            res_cnt       = 2'd1;
            res0.kind     = K_VAL_CHAR;
            res0.char_out = data_byte;
          end else if (!sp) begin
            mode_nxt  = M_BETWEEN;
            res_cnt   = 2'd1;
            res0.kind = K_PAIR_END;
          end
        end
        M_VALUE: begin
          res_cnt = 2'd1;
          if (nm) begin
            res0.kind     = K_VAL_CHAR;
            res0.char_out = data_byte;
          end else begin
            mode_nxt  = M_BETWEEN;
            res0.kind = K_PAIR_END;
          end
        end
        default: mode_nxt = M_ERROR;
      endcase
    end
  end

endmodule

// ----- rtl/ist_resq.sv -----
// ----------------------------------------------------------------------------
// ist_resq
// Small result queue: takes up to two results per cycle, hands out one per cycle while rd_stall is low.
// ----------------------------------------------------------------------------
module ist_resq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [1:0]                 wr_cnt,
  input  ist_pkg::res_t              wr0,
  input  ist_pkg::res_t              wr1,
  output logic                       room2,
  output logic                       rd_valid,
  input  logic                       rd_stall,
  output ist_pkg::res_t              rd_data
);
  import ist_pkg::*;

  res_t           mem_r [QDEPTH];
  logic [QAW-1:0] head_r, head_nxt;
  logic [QAW-1:0] tail_r, tail_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           pop;

  assign rd_valid = count_r != '0;
  assign pop      = rd_valid && !rd_stall;
  assign rd_data  = mem_r[head_r];
  assign room2    = count_r <= (QAW+1)'(QDEPTH - 2);

  assign head_nxt  = head_r + QAW'(pop);
  assign tail_nxt  = tail_r + QAW'(wr_cnt);
  assign count_nxt = count_r + (QAW+1)'(wr_cnt) - (QAW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) mem_r[tail_r] <= wr0;
    if (wr_cnt == 2'd2) mem_r[tail_r + QAW'(1)] <= wr1;
  end

endmodule

// ----- rtl/ini_stream_tokenizer.sv -----
// ----------------------------------------------------------------------------
// ini_stream_tokenizer
// Streaming INI tokenizer: one text byte or end marker in, token events out.
// ----------------------------------------------------------------------------
// One input transfer is taken per cycle while in_stall is low. The decode of
// mode plus byte is combinational and mode_r registers the next mode; the
// results (zero, one or two) go into a four-entry result queue and leave it in
// order on the out_ channel, one per cycle while out_stall is low. in_stall
// rises only while fewer than two queue entries are free, so throughput is one
// item per cycle as long as results are drained at least as fast as they are
// made. After an error the block emits nothing until reset.
module ini_stream_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_char_out,
  output logic [2:0] out_err_code,
  output logic       out_last
);
  import ist_pkg::*;

  logic [3:0] mode_r, mode_nxt, dec_mode;
  logic [1:0] dec_cnt, wr_cnt;
  res_t       dec_res0, dec_res1, rd_data;
  logic       room2;
  logic       in_fire;

  assign in_stall = !room2;
  assign in_fire  = in_valid && !in_stall;

  ist_decode u_decode (
    .mode      (mode_r),
    .op        (in_op),
    .data_byte (in_data_byte),
    .mode_nxt  (dec_mode),
    .res_cnt   (dec_cnt),
    .res0      (dec_res0),
    .res1      (dec_res1)
  );

  assign mode_nxt = in_fire ? dec_mode : mode_r;
  assign wr_cnt   = in_fire ? dec_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_BETWEEN;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  ist_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cnt   (wr_cnt),
    .wr0      (dec_res0),
    .wr1      (dec_res1),
    .room2    (room2),
    .rd_valid (out_valid),
    .rd_stall (out_stall),
    .rd_data  (rd_data)
  );

  assign out_kind     = rd_data.kind;
  assign out_char_out = rd_data.char_out;
  assign out_err_code = rd_data.err_code;
  assign out_last     = rd_data.last;

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_ERROR |=> mode_r == M_ERROR)
    else $error("error mode left without reset");

  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mode_r == M_ERROR) |-> wr_cnt == 2'd0)
    else $error("result produced in error mode");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty result queue");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == K_ERROR) |-> out_last)
    else $error("error result not marked last");

endmodule

// ----- tb/tb_ini_stream_tokenizer.sv -----
// ----------------------------------------------------------------------------
// tb_ini_stream_tokenizer
// Self-checking testbench for the streaming INI tokenizer.
// ----------------------------------------------------------------------------
// A directed text exercises every non-error token kind and end-item outcome,
// name and whitespace extremes and a value-less pair. Random well-formed INI
// text (sections, comments, key/value pairs, end items) follows in four
// flow-control phases. Because an error is sticky until reset, the run closes
// with one randomly chosen fault and a few items that must stay silent.
// A scoreboard class tracks the tokenizer mode and checks every result
// transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ini_stream_tokenizer;
  import ist_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 500;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [2:0] NO_ERR = 3'd0;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_op;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_kind;
  logic [7:0] out_char_out;
  logic [2:0] out_err_code;
  logic       out_last;

  int src_idle;
  int sink_stall;
  int n_sent;
  int cycle_count;
  logic [2:0] fault_sel;

  ini_stream_tokenizer uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_char_out (out_char_out),
    .out_err_code (out_err_code),
    .out_last     (out_last)
  );

  function automatic bit name_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == CH_UNDER;
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  class token_scoreboard;
    logic [3:0] mode;
    res_t       pending[$];
    int         errors;
    int         n_items;
    int         n_results;

    function new();
      mode = M_BETWEEN;
    endfunction

    function void emit(logic [2:0] kind, logic [7:0] ch, logic [2:0] err);
      res_t r;
      r.kind     = kind;
      r.char_out = ch;
      r.err_code = err;
      r.last     = 1'b0;
      pending.push_back(r);
    endfunction

    function void fault(logic [2:0] code);
      mode = M_ERROR;
      emit(K_ERROR, 8'h00, code);
    endfunction

    function void note_input(logic op, logic [7:0] c);
      int   base;
      res_t r;
      base = pending.size();
      n_items++;
      if (op == OP_END) begin
        case (mode)
          M_BETWEEN, M_DROP: begin
            emit(K_DONE, 8'h00, NO_ERR);
            mode = M_BETWEEN;
          end
          M_AFTER_EQ, M_VALUE: begin
            emit(K_PAIR_END, 8'h00, NO_ERR);
            emit(K_DONE, 8'h00, NO_ERR);
            mode = M_BETWEEN;
          end
          M_COMMENT, M_SEC_START, M_SEC_NAME, M_KEY, M_BEFORE_EQ:
            fault(E_EARLY_END);
          default: ;
        endcase
      end else begin
        case (mode)
          M_BETWEEN: begin
            if (blank_char(c)) begin
            end else if (c == CH_LBRACK) begin
              mode = M_SEC_START;
            end else if (c == CH_SEMI) begin
              mode = M_COMMENT;
            end else if (name_char(c)) begin
              mode = M_KEY;
              emit(K_KEY_CHAR, c, NO_ERR);
            end else begin
              fault(E_ILLEGAL);
            end
          end
          M_COMMENT: begin
            if (c == CH_LF) mode = M_BETWEEN;
          end
          M_SEC_START: begin
            if (name_char(c)) begin
              mode = M_SEC_NAME;
              emit(K_SEC_CHAR, c, NO_ERR);
            end else begin
              fault(E_BAD_SECTION);
            end
          end
          M_SEC_NAME: begin
            if (name_char(c)) begin
              emit(K_SEC_CHAR, c, NO_ERR);
            end else if (c == CH_RBRACK) begin
              mode = M_DROP;
              emit(K_SEC_END, 8'h00, NO_ERR);
            end else begin
              fault(E_NO_BRACKET);
            end
          end
          M_DROP: mode = M_BETWEEN;
          M_KEY: begin
            if (name_char(c)) begin
              emit(K_KEY_CHAR, c, NO_ERR);
            end else if (c == CH_EQ) begin
              mode = M_AFTER_EQ;
            end else if (blank_char(c)) begin
              mode = M_BEFORE_EQ;
            end else begin
              fault(E_NO_EQUALS);
            end
          end
          M_BEFORE_EQ: begin
            if (c == CH_EQ) begin
              mode = M_AFTER_EQ;
            end else if (!blank_char(c)) begin
              fault(E_NO_EQUALS);
            end
          end
          M_AFTER_EQ: begin
            if (name_char(c)) begin
              mode = M_VALUE;
              emit(K_VAL_CHAR, c, NO_ERR);
            end else if (!blank_char(c)) begin
              mode = M_BETWEEN;
              emit(K_PAIR_END, 8'h00, NO_ERR);
            end
          end
          M_VALUE: begin
            if (name_char(c)) begin
              emit(K_VAL_CHAR, c, NO_ERR);
            end else begin
              mode = M_BETWEEN;
              emit(K_PAIR_END, 8'h00, NO_ERR);
            end
          end
          default: ;
        endcase
      end
      if (pending.size() > base) begin
        r = pending.pop_back();
        r.last = 1'b1;
        pending.push_back(r);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      n_results++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d char=%02h err=%0d last=%0b",
                 $time, got.kind, got.char_out, got.err_code, got.last);
      end else begin
        want = pending.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch exp kind=%0d char=%02h err=%0d last=%0b",
                   $time, want.kind, want.char_out, want.err_code, want.last);
          $display("%0t:          got kind=%0d char=%02h err=%0d last=%0b",
                   $time, got.kind, got.char_out, got.err_code, got.last);
        end
      end
    endfunction
  endclass

  token_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  always @(negedge clk) begin
    out_stall = rst_n && ($urandom_range(99) < sink_stall);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_op, in_data_byte);
      if (out_valid && !out_stall)
        sb.check_result({out_kind, out_char_out, out_err_code, out_last});
    end
  end

  // Called and returns at a falling edge.
  task automatic send_item(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < src_idle) begin
      in_valid     = 1'b0;
      in_op        = 1'($urandom_range(1));
      in_data_byte = 8'($urandom_range(255));
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_op        = op;
    in_data_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_DATA, b);
  endtask

  task automatic send_end();
    send_item(OP_END, 8'($urandom_range(255)));
  endtask

  function automatic logic [7:0] rand_name();
    int r;
    r = $urandom_range(62);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    if (r < 62) return 8'("a" + r - 36);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Random byte that is not a name char, optionally not blank, and not x1/x2.
  function automatic logic [7:0] odd_byte(input bit blank_ok,
                                          input logic [7:0] x1,
                                          input logic [7:0] x2);
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (name_char(c) || (!blank_ok && blank_char(c)) || c == x1 || c == x2);
    return c;
  endfunction

  function automatic logic [7:0] comment_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_LF);
    return c;
  endfunction

  task automatic send_names(input int lo, input int hi);
    int len;
    len = $urandom_range(hi, lo);
    repeat (len) send_byte(rand_name());
  endtask

  task automatic send_blanks(input int lo, input int hi);
    int len;
    len = $urandom_range(hi, lo);
    repeat (len) send_byte(rand_blank());
  endtask

  task automatic send_directed();
    send_byte(CH_LBRACK); send_byte(CH_UNDER); send_byte("Z");
    send_byte(CH_RBRACK); send_byte(8'hFF); send_end();
    send_byte("a"); send_byte("9"); send_byte(CH_SPACE); send_byte(CH_EQ);
    send_byte(CH_CR); send_byte(","); send_byte(CH_SEMI); send_byte(8'h80);
    send_byte(CH_LF); send_byte("z"); send_byte(CH_EQ); send_byte("A");
    send_byte("0"); send_end();
    send_byte(CH_TAB); send_byte("k"); send_byte(CH_EQ); send_end();
    send_byte(CH_LBRACK); send_byte("x"); send_byte(CH_RBRACK); send_end();
  endtask

  // One well-formed entry; leaves the tokenizer between entries.
  task automatic send_entry();
    int  r;
    int  vlen;
    r = $urandom_range(99);
    if (r < 10) begin
      send_blanks(1, 3);
    end else if (r < 20) begin
      send_byte(CH_SEMI);
      repeat ($urandom_range(8)) send_byte(comment_byte());
      send_byte(CH_LF);
    end else if (r < 40) begin
      send_byte(CH_LBRACK);
      send_names(1, 6);
      send_byte(CH_RBRACK);
      if ($urandom_range(9) == 0) send_end();
      else send_byte(8'($urandom_range(255)));
    end else if (r < 92) begin
      send_names(1, 6);
      if ($urandom_range(1)) send_blanks(1, 2);
      send_byte(CH_EQ);
      send_blanks(0, 2);
      vlen = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      repeat (vlen) send_byte(rand_name());
      if ($urandom_range(4) == 0) send_end();
      else send_byte(odd_byte(vlen > 0, CH_UNDER, CH_UNDER));
    end else begin
      send_end();
    end
  endtask

  // Errors are sticky until reset, so exactly one fault closes the run.
  task automatic send_fault();
    fault_sel = 3'($urandom_range(4));
    case (fault_sel)
      E_ILLEGAL: send_byte(odd_byte(1'b0, CH_LBRACK, CH_SEMI));
      E_BAD_SECTION: begin
        send_byte(CH_LBRACK);
        send_byte(odd_byte(1'b1, CH_UNDER, CH_UNDER));
      end
      E_NO_BRACKET: begin
        send_byte(CH_LBRACK);
        send_names(1, 4);
        send_byte(odd_byte(1'b1, CH_RBRACK, CH_RBRACK));
      end
      E_NO_EQUALS: begin
        send_names(1, 4);
        if ($urandom_range(1)) send_blanks(1, 2);
        send_byte(odd_byte(1'b0, CH_EQ, CH_EQ));
      end
      default: begin
        case ($urandom_range(4))
          0: begin
            send_byte(CH_SEMI);
            repeat ($urandom_range(3)) send_byte(comment_byte());
          end
          1: send_byte(CH_LBRACK);
          2: begin
            send_byte(CH_LBRACK);
            send_names(1, 4);
          end
          3: send_names(1, 4);
          default: begin
            send_names(1, 4);
            send_blanks(1, 2);
          end
        endcase
        send_end();
      end
    endcase
    repeat (8) send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int target;
    idle_tab  = '{0, 62, 0, 22};
    stall_tab = '{0, 0, 62, 22};
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_op        = OP_DATA;
    in_data_byte = 8'h00;
    out_stall    = 1'b0;
    src_idle     = 0;
    sink_stall   = 0;
    n_sent       = 0;
    fault_sel    = E_ILLEGAL;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    send_directed();
    for (int ph = 0; ph < 4; ph++) begin
      src_idle   = idle_tab[ph];
      sink_stall = stall_tab[ph];
      target     = n_sent + PHASE_ITEMS;
      while (n_sent < target) send_entry();
    end
    send_fault();
    in_valid = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Tokenized %0d input transfers into %0d checked results,", sb.n_items,
             sb.n_results);
    $display("across four flow-control phases, ending in sticky fault code %0d.",
             fault_sel);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ist_pkg.sv
rtl/ist_decode.sv
rtl/ist_resq.sv
rtl/ini_stream_tokenizer.sv
tb/tb_ini_stream_tokenizer.sv
